[src/hqs_pkg.sv]
// Shared types and constants for the hour and quarter strike sequencer.
// Used by the top level; depends on nothing.
package hqs_pkg;

	localparam logic [4:0]  HOURS_ON_DIAL     = 5'd12;
	localparam logic [4:0]  HOURS_TWICE       = 5'd24;
	localparam logic [2:0]  QUARTERS_PER_HOUR = 3'd4;
	localparam logic [15:0] STRIKE_GAP_RESET  = 16'd1000;
	localparam logic [15:0] HOUR_GAP_RESET    = 16'd3000;
	localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_TICK      = 3'd0,
		ACT_HOUR_QTRS = 3'd1,
		ACT_HOUR_ONLY = 3'd2,
		ACT_QUARTERS  = 3'd3,
		ACT_HALF_HOUR = 3'd4,
		ACT_STOP      = 3'd5,
		ACT_ACK       = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		REG_BELL_COUNT = 2'd0,
		REG_STRIKE_GAP = 2'd1,
		REG_HOUR_GAP   = 2'd2
	} reg_index_t;

	// Bell codes on the result, 1-based; zero means no bell
	localparam logic [1:0] BELL_NONE    = 2'd0;
	localparam logic [1:0] BELL_HOUR    = 2'd1;
	localparam logic [1:0] BELL_QUARTER = 2'd2;

	typedef struct packed {
		action_t    action;
		logic [4:0] hour;
		logic [2:0] quarter_count;
	} cmd_item_t;

	typedef struct packed {
		logic       strike_now;
		logic [1:0] strike_bell;
		logic [1:0] last_bell;
		logic       busy_res;
	} res_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_item_t;

	// Number of hour strikes: hour modulo 12, with 0 striking 12
	function automatic logic [4:0] hour_strikes(input logic [4:0] hour);
		logic [4:0] h;
		if (hour >= HOURS_TWICE) begin
			h = hour - HOURS_TWICE;
		end else if (hour >= HOURS_ON_DIAL) begin
			h = hour - HOURS_ON_DIAL;
		end else begin
			h = hour;
		end
		return (h == 5'd0) ? HOURS_ON_DIAL : h;
	endfunction

endpackage

[src/hqs_stream_if.sv]
// Valid/ready channel carrying one packed payload per transfer.
// Payload types come from hqs_pkg.
interface hqs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/hour_quarter_strike_sequencer.sv]
// Tower-clock hour and quarter strike sequencer, top level.
// A command is held in the input register, and its result in the result register.
// Throughput: one command or tick per cycle while the result register is empty or drained;
// all work sits between those two registers. Reset (arst_n low, asynchronous): sequence idle,
// first strike pending, last bell cleared, bell_count 0, strike gap 1000 ms, hour gap 3000 ms.
// Depends on hqs_pkg and hqs_stream_if.
module hour_quarter_strike_sequencer
	import hqs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hqs_stream_if.sink   cmd,
	hqs_stream_if.source res,
	hqs_stream_if.sink   cfg
);

	// ---------------------------------------------------------------
	// Configuration registers. The user must write them only while idle;
	// the block does not enforce this, and the datapath reads them directly.
	// ---------------------------------------------------------------
	logic [4:0]  bell_count_q;
	logic [15:0] strike_gap_q;
	logic [15:0] hour_gap_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bell_count_q <= 5'd0;
			strike_gap_q <= STRIKE_GAP_RESET;
			hour_gap_q   <= HOUR_GAP_RESET;
		end else if (cfg.valid) begin
			unique case (reg_index_t'(cfg.data.index))
				REG_BELL_COUNT: bell_count_q <= cfg.data.data[4:0];
				REG_STRIKE_GAP: strike_gap_q <= cfg.data.data;
				REG_HOUR_GAP:   hour_gap_q   <= cfg.data.data;
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control: input register, then result register. The stage
	// advances whenever the result register is empty or being drained,
	// so a new command is taken while a finished result still waits.
	// ---------------------------------------------------------------
	logic      valid_s1;
	cmd_item_t item_s1;
	logic      res_valid_q;
	res_item_t res_q;
	logic      advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Sequence state
	// ---------------------------------------------------------------
	logic [4:0]  seq_len_q, seq_len_d;
	logic [4:0]  pos_q, pos_d;
	logic [2:0]  qtrs_q, qtrs_d;
	logic        playing_q, playing_d;
	logic        first_q, first_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [1:0]  sticky_q, sticky_d;
	res_item_t   res_d;

	// per-tick helpers
	logic        active;
	logic [15:0] elapsed_inc;
	logic [15:0] gap;
	logic        fire;
	logic        quarter_bell;
	logic        bell_present;
	logic [2:0]  qc_sat;

	always_comb begin
		seq_len_d = seq_len_q;
		pos_d     = pos_q;
		qtrs_d    = qtrs_q;
		playing_d = playing_q;
		first_d   = first_q;
		elapsed_d = elapsed_q;
		sticky_d  = sticky_q;
		res_d     = '0;

		active      = playing_q && (pos_q < seq_len_q);
		// Hold the count while the first strike is pending; saturate at the top
		elapsed_inc = (!first_q && elapsed_q != ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;
		// The first hour strike after quarters waits the long gap
		gap         = (pos_q == {2'b00, qtrs_q} && pos_q != 5'd0) ? hour_gap_q : strike_gap_q;
		fire        = first_q || (elapsed_inc >= gap);
		quarter_bell = pos_q < {2'b00, qtrs_q};
		bell_present = quarter_bell ? (bell_count_q > 5'd1) : (bell_count_q != 5'd0);
		qc_sat      = (item_s1.quarter_count > QUARTERS_PER_HOUR) ? QUARTERS_PER_HOUR
		                                                          : item_s1.quarter_count;

		unique case (item_s1.action)
			ACT_TICK: begin
				if (active) begin
					elapsed_d = elapsed_inc;
					if (fire) begin
						// A missing bell is skipped silently; timing still advances
						if (bell_present) begin
							res_d.strike_now  = 1'b1;
							res_d.strike_bell = quarter_bell ? BELL_QUARTER : BELL_HOUR;
							sticky_d          = quarter_bell ? BELL_QUARTER : BELL_HOUR;
						end
						first_d   = 1'b0;
						elapsed_d = 16'd0;
						pos_d     = pos_q + 5'd1;
						if (pos_q + 5'd1 >= seq_len_q) begin
							playing_d = 1'b0;
						end
					end
				end
			end
			ACT_HOUR_QTRS, ACT_HOUR_ONLY, ACT_QUARTERS, ACT_HALF_HOUR: begin
				// Restart: any running sequence is dropped
				case (item_s1.action)
					ACT_HOUR_QTRS: qtrs_d = QUARTERS_PER_HOUR;
					ACT_QUARTERS:  qtrs_d = qc_sat;
					ACT_HALF_HOUR: qtrs_d = 3'd1;
					default:       qtrs_d = 3'd0;
				endcase
				if (item_s1.action == ACT_HOUR_QTRS || item_s1.action == ACT_HOUR_ONLY) begin
					seq_len_d = {2'b00, qtrs_d} + hour_strikes(item_s1.hour);
				end else begin
					seq_len_d = {2'b00, qtrs_d};
				end
				pos_d     = 5'd0;
				first_d   = 1'b1;
				elapsed_d = 16'd0;
				playing_d = seq_len_d != 5'd0;
			end
			ACT_STOP: begin
				playing_d = 1'b0;
				seq_len_d = 5'd0;
				pos_d     = 5'd0;
				qtrs_d    = 3'd0;
			end
			ACT_ACK: begin
				sticky_d = BELL_NONE;
			end
			default: ;  // unused action code: no change
		endcase

		if (item_s1.action == ACT_TICK) begin
			res_d.last_bell = active ? sticky_d : BELL_NONE;
		end else begin
			res_d.last_bell = playing_d ? sticky_d : BELL_NONE;
		end
		res_d.busy_res = playing_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= 5'd0;
			pos_q     <= 5'd0;
			qtrs_q    <= 3'd0;
			playing_q <= 1'b0;
			first_q   <= 1'b1;
			elapsed_q <= 16'd0;
			sticky_q  <= BELL_NONE;
		end else if (advance) begin
			seq_len_q <= seq_len_d;
			pos_q     <= pos_d;
			qtrs_q    <= qtrs_d;
			playing_q <= playing_d;
			first_q   <= first_d;
			elapsed_q <= elapsed_d;
			sticky_q  <= sticky_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// A running sequence always has strikes left
	a_playing_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> (pos_q < seq_len_q))
		else $error("playing with no strikes left");

	// Quarter count never exceeds one hour's worth
	a_qtrs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		qtrs_q <= QUARTERS_PER_HOUR)
		else $error("quarter count out of range");

	// A strike on the result always shows up as the sticky last bell
	a_strike_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.strike_now) |->
		(res_q.strike_bell != BELL_NONE && res_q.last_bell == res_q.strike_bell))
		else $error("strike not reflected in last bell");

	// The sticky bell changes only on a strike or an acknowledge
	a_sticky_source: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && sticky_d != sticky_q) |->
		(res_d.strike_now || item_s1.action == ACT_ACK))
		else $error("sticky bell changed without cause");

endmodule
